[hw/rtl/lgs_pkg.sv]
// Shared types and constants for the life generation step block.
package lgs_pkg;

  localparam int unsigned CfgW = 7;
  localparam int unsigned GenW = 32;
  localparam logic [CfgW-1:0] CfgReset = 7'd64;

  // B3/S23
  localparam logic [3:0] BirthCount = 4'd3;
  localparam logic [3:0] SurviveCount = 4'd2;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_e;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic latch_req;
    logic clr_we;
    logic wr_cell;
    logic step_init;
    logic load_cur;
    logic row_update;
    logic step_done;
    logic rd_cell;
    logic load_out;
  } lgs_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic area_empty;
    logic last_row;
    logic slot_free;
  } lgs_status_t;

endpackage

[hw/rtl/lgs_ctrl.sv]
// Sequencer for clear pass, cell access and generation sweep.
module lgs_ctrl
  import lgs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  req_type_i,
  input  lgs_status_t status_i,
  output logic        in_ready_o,
  output lgs_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_STEP_START,
    ST_STEP_LOAD,
    ST_STEP_ROW,
    ST_FETCH,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          unique case (req_e'(req_type_i))
            REQ_WRITE: state_d = ST_WRITE;
            REQ_STEP:  state_d = ST_STEP_START;
            default:   state_d = ST_FETCH;
          endcase
        end
      end
      ST_WRITE: begin
        cmd_o.wr_cell = 1'b1;
        state_d = ST_FETCH;
      end
      ST_STEP_START: begin
        cmd_o.step_init = 1'b1;
        if (status_i.area_empty) begin
          cmd_o.step_done = 1'b1;
          state_d = ST_FETCH;
        end else begin
          state_d = ST_STEP_LOAD;
        end
      end
      ST_STEP_LOAD: begin
        cmd_o.load_cur = 1'b1;
        state_d = ST_STEP_ROW;
      end
      ST_STEP_ROW: begin
        cmd_o.row_update = 1'b1;
        if (status_i.last_row) begin
          cmd_o.step_done = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.rd_cell = 1'b1;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

[hw/rtl/lgs_dpath.sv]
// Grid memory, three-row window, rule logic, counters and output register.
module lgs_dpath
  import lgs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lgs_cmd_t         cmd_i,
  output lgs_status_t      status_o,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic [1:0]       req_type_i,
  input  logic [5:0]       row_index_i,
  input  logic [5:0]       col_index_i,
  input  logic             write_value_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             cell_value_o,
  output logic             grid_changed_o,
  output logic [GenW-1:0]  generation_o
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW = $clog2(MAX_COLS + 1);

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];

  logic [CfgW-1:0]     rows_q, cols_q;
  logic [NRW-1:0]      nr_eff;
  logic [NCW-1:0]      nc_eff;
  logic [RW-1:0]       row_q;
  logic [NRW:0]        row_plus2;
  logic                next_in_area;

  logic [1:0]          req_q;
  logic [5:0]          req_row_q, req_col_q;
  logic                req_wv_q;
  logic                req_inside;

  logic                rd_en;
  logic [RW-1:0]       rd_addr;
  logic [MAX_COLS-1:0] rd_data_q;

  logic [MAX_COLS-1:0] prev_q, cur_q, mask_q, mask_d, next_row, new_row;
  logic [MAX_COLS-1:0] pm, cm, nm, pl, pr, cl, cr, nl, nr_sh;
  logic [3:0]          cnt;
  logic                chg_q;
  logic [GenW-1:0]     gen_q;

  logic                out_valid_q, out_cell_q, out_chg_q;
  logic [GenW-1:0]     out_gen_q;

  // effective area, capped at storage
  assign nr_eff = (32'(rows_q) > MAX_ROWS) ? NRW'(MAX_ROWS) : NRW'(rows_q);
  assign nc_eff = (32'(cols_q) > MAX_COLS) ? NCW'(MAX_COLS) : NCW'(cols_q);

  assign row_plus2    = (NRW+1)'(row_q) + (NRW+1)'(2);
  assign next_in_area = (NRW'(row_q) + NRW'(1)) != nr_eff;
  assign req_inside   = (32'(req_row_q) < MAX_ROWS) && (32'(req_col_q) < MAX_COLS);

  assign status_o.clear_last = (row_q == RW'(MAX_ROWS - 1));
  assign status_o.area_empty = (nr_eff == '0);
  assign status_o.last_row   = !next_in_area;
  assign status_o.slot_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgReset;
      cols_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default:  rows_q <= rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q     <= req_type_i;
      req_row_q <= row_index_i;
      req_col_q <= col_index_i;
      req_wv_q  <= write_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (cmd_i.step_init) begin
      row_q <= '0;
    end else if (cmd_i.clr_we || cmd_i.row_update) begin
      row_q <= row_q + RW'(1);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.step_init) begin
      rd_en   = (nr_eff != '0);
      rd_addr = '0;
    end else if (cmd_i.load_cur) begin
      rd_en   = (nr_eff > NRW'(1));
      rd_addr = RW'(1);
    end else if (cmd_i.row_update) begin
      rd_en   = (row_plus2 < (NRW+1)'(nr_eff));
      rd_addr = RW'(row_plus2);
    end else if (cmd_i.rd_cell) begin
      rd_en   = req_inside;
      rd_addr = RW'(req_row_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.clr_we) begin
      mem_q[row_q] <= '0;
    end else if (cmd_i.row_update) begin
      mem_q[row_q] <= new_row;
    end else if (cmd_i.wr_cell && req_inside) begin
      mem_q[RW'(req_row_q)][CW'(req_col_q)] <= req_wv_q;
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      mask_d[c] = (c < int'(nc_eff));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_init) begin
      mask_q <= mask_d;
    end
    if (cmd_i.load_cur) begin
      prev_q <= '0;
      cur_q  <= rd_data_q;
    end else if (cmd_i.row_update) begin
      prev_q <= cur_q;
      cur_q  <= rd_data_q;
    end
  end

  assign next_row = next_in_area ? rd_data_q : '0;

  // neighbor at c-1 comes from a left shift, at c+1 from a right shift
  always_comb begin
    pm    = prev_q & mask_q;
    cm    = cur_q & mask_q;
    nm    = next_row & mask_q;
    pl    = pm << 1;
    pr    = pm >> 1;
    cl    = cm << 1;
    cr    = cm >> 1;
    nl    = nm << 1;
    nr_sh = nm >> 1;
    cnt   = '0;
    new_row = cur_q;
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = 4'(pl[c]) + 4'(pm[c]) + 4'(pr[c]) + 4'(cl[c]) + 4'(cr[c])
          + 4'(nl[c]) + 4'(nm[c]) + 4'(nr_sh[c]);
      if (mask_q[c]) begin
        new_row[c] = (cnt == BirthCount) || (cur_q[c] && (cnt == SurviveCount));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chg_q <= 1'b0;
      gen_q <= '0;
    end else begin
      if (cmd_i.step_init) begin
        chg_q <= 1'b0;
      end else if (cmd_i.row_update) begin
        chg_q <= chg_q || (|(new_row ^ cur_q));
      end
      if (cmd_i.step_done) begin
        gen_q <= gen_q + GenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cell_q <= req_inside && rd_data_q[CW'(req_col_q)];
      out_chg_q  <= (req_e'(req_q) == REQ_STEP) && chg_q;
      out_gen_q  <= gen_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_value_o   = out_cell_q;
  assign grid_changed_o = out_chg_q;
  assign generation_o   = out_gen_q;

`ifndef SYNTH
  a_gen_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_done |=> gen_q == $past(gen_q) + GenW'(1))
    else $error("generation did not advance on step completion");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an item not yet taken");

  a_row_in_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_update |-> NRW'(row_q) < nr_eff)
    else $error("row update outside configured area");
`endif

endmodule

[hw/rtl/life_generation_step.sv]
// Top level of the life generation step block: B3/S23 grid with cell access.
//
// channel  direction  handshake                  payload
// cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i / in_ready_o    req_type_i, row_index_i, col_index_i,
//                                                write_value_i
// out      out        out_valid_o / out_ready_i  cell_value_o, grid_changed_o, generation_o
//
// After reset a clearing pass writes MAX_ROWS grid rows, one per cycle; no item is
// taken until it ends. Configuration writes are always taken.
// A step sweeps min(rows_in_use, MAX_ROWS) rows, one grid row per cycle through the
// single memory read port and the three-row window; with no rows in use the sweep is
// skipped and only the generation count advances.
// A finished result waits in the output register; the next item is accepted meanwhile.
module life_generation_step
  import lgs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [5:0]       row_index_i,
  input  logic [5:0]       col_index_i,
  input  logic             write_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             cell_value_o,
  output logic             grid_changed_o,
  output logic [GenW-1:0]  generation_o
);

  lgs_cmd_t    cmd;
  lgs_status_t status;

  assign cfg_ready_o = 1'b1;

  lgs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lgs_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .write_value_i  (write_value_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .cell_value_o   (cell_value_o),
    .grid_changed_o (grid_changed_o),
    .generation_o   (generation_o)
  );

endmodule
